// ===== design/orps_pkg.sv =====
// Shared types, constants and helpers for the rectangle-path odometry sequencer.
// Used by orps_mul, odometry_rectangle_path_sequencer_unit and the testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package orps_pkg;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;

  // angle constants, Q8.24 radians
  localparam logic signed [33:0] Q_PI       = 34'sd52707179;
  localparam logic signed [33:0] Q_TWO_PI   = 34'sd105414357;
  localparam logic signed [33:0] Q_HALF_PI  = 34'sd26353589;
  // CORDIC start value, Q2.30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // configuration register indexes
  localparam logic [2:0] REG_METERS_PER_TICK   = 3'd0;
  localparam logic [2:0] REG_INV_WHEEL_BASE    = 3'd1;
  localparam logic [2:0] REG_SHORT_EDGE_LENGTH = 3'd2;
  localparam logic [2:0] REG_LONG_EDGE_LENGTH  = 3'd3;
  localparam logic [2:0] REG_TURN_ANGLE        = 3'd4;
  localparam logic [2:0] REG_EDGE_LIMIT        = 3'd5;

  typedef enum logic [1:0] {
    CMD_STOP    = 2'd0,
    CMD_FORWARD = 2'd1,
    CMD_TURN    = 2'd2
  } move_cmd_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] res;
    if (v > 66'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // arctangent of 2^-i, Q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] res;
    case (i)
      5'd0:  res = 32'd843314856;
      5'd1:  res = 32'd497837829;
      5'd2:  res = 32'd263043836;
      5'd3:  res = 32'd133525158;
      5'd4:  res = 32'd67021686;
      5'd5:  res = 32'd33543515;
      5'd6:  res = 32'd16771754;
      5'd7:  res = 32'd8388437;
      5'd8:  res = 32'd4194282;
      5'd9:  res = 32'd2097149;
      5'd10: res = 32'd1048575;
      5'd11: res = 32'd524287;
      5'd12: res = 32'd262143;
      5'd13: res = 32'd131071;
      5'd14: res = 32'd65535;
      5'd15: res = 32'd32767;
      5'd16: res = 32'd16383;
      5'd17: res = 32'd8191;
      5'd18: res = 32'd4095;
      5'd19: res = 32'd2047;
      5'd20: res = 32'd1023;
      5'd21: res = 32'd511;
      5'd22: res = 32'd255;
      5'd23: res = 32'd127;
      5'd24: res = 32'd63;
      5'd25: res = 32'd31;
      5'd26: res = 32'd15;
      5'd27: res = 32'd8;
      5'd28: res = 32'd4;
      5'd29: res = 32'd2;
      5'd30: res = 32'd1;
      default: res = 32'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/odometry_rectangle_path_sequencer_unit.sv =====
// Top level of the rectangle-path odometry sequencer: stream ports, sequencer,
// CORDIC and angle reduction. Depends on orps_pkg and orps_mul.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   in_*  : one beat per encoder sample, tdata = {left_ticks, right_ticks}.
//   out_* : one beat per sample with the drive command and the updated pose.
//   cfg_* : register writes (index, data), always ready; write only when idle.
// Each sample runs through a small sequencer that reuses one 33x33 multiplier
// for the wheel steps, heading change and position increments, a six-step
// subtract loop for the angle reduction and one CORDIC rotation per cycle.
// The result is loaded into the output register in S_OUT, and the next input
// can be taken in the cycle after the result is loaded.
// in_tready is low while a sample is in work. The result waits in an output
// register; a stalled receiver holds the block before that register is
// reloaded, so nothing is lost. Reset restores the register defaults, clears
// the pose and arms the first-sample capture of the encoder counts.

module odometry_rectangle_path_sequencer_unit #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire          clk,
  input  wire          rst_n,
  // tdata: right_ticks[31:0], left_ticks[63:32]
  input  wire  [63:0]  in_tdata,
  input  wire          in_tvalid,
  output logic         in_tready,
  // tdata: move_cmd[1:0], pos_x[33:2], pos_y[65:34], heading[97:66],
  //        edge_distance[129:98], edges_done[137:130], zero[143:138]
  output logic [143:0] out_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [2:0]   cfg_index,
  input  wire  [31:0]  cfg_data
);
  import orps_pkg::*;

  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MR, S_ML, S_WL, S_SD, S_MD, S_DTH, S_ANG,
    S_MOD, S_FOLD, S_ROT, S_RND, S_MX, S_MY, S_FIN, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [31:0] mpt_r;
  logic [30:0] iwb_r, short_len_r, long_len_r, turn_ang_r;
  logic [7:0]  edge_limit_r;

  // odometry and sequencer state
  logic               first_r;
  logic signed [31:0] prev_r_r, prev_l_r;
  logic signed [31:0] x_est_r, y_est_r, theta_est_r, edge_dist_r, turn_tgt_r;
  logic               turning_r, short_next_r;
  logic [7:0]         edge_cnt_r;
  move_cmd_t          cmd_r;

  // per-sample working registers
  logic signed [31:0] dr_r, dl_r, rs_r, ls_r, s_r, d_r, dth_r, theta_new_r;
  logic               ang_neg_r;
  logic [33:0]        mag_r;
  logic [2:0]         mod_k_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic               fneg_r;
  logic [CW-1:0]      cnt_r;
  logic signed [MUL_W-1:0] c_r, sn_r;

  logic               out_tvalid_r;
  logic [143:0]       out_tdata_r;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  orps_mul u_mul (
    .clk    (clk),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    case (state_r)
      S_MR: begin
        mul_a = MUL_W'(dr_r);
        mul_b = {1'b0, mpt_r};
      end
      S_ML: begin
        mul_a = MUL_W'(dl_r);
        mul_b = {1'b0, mpt_r};
      end
      S_MD: begin
        mul_a = MUL_W'(d_r);
        mul_b = {2'b00, iwb_r};
      end
      S_MX: begin
        mul_a = c_r;
        mul_b = MUL_W'(s_r);
      end
      S_MY: begin
        mul_a = sn_r;
        mul_b = MUL_W'(s_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // rounding of the product: wheel step (>> 8) and Q8.24 result (>> 24)
  logic signed [PROD_W-1:0] prod_r8, prod_r24;
  logic signed [31:0]       step_q, prod_q24;
  assign prod_r8  = (prod + PROD_W'(128)) >>> 8;
  assign prod_r24 = (prod + PROD_W'(64'sd8388608)) >>> 24;
  assign step_q   = sat32(prod_r8);
  assign prod_q24 = sat32(prod_r24);

  // angle for the sine/cosine: theta + half the heading change
  logic signed [33:0] ang;
  assign ang = 34'(theta_est_r) + 34'(dth_r >>> 1);

  // modulo loop step
  logic [33:0] mod_sub;
  assign mod_sub = 34'(Q_TWO_PI) << mod_k_r;

  // wrap into [-pi, pi) and fold into [-pi/2, pi/2]
  logic signed [33:0] rem0, rem1, rem2, rem3;
  logic               fold_neg;
  always_comb begin
    rem0 = ang_neg_r ? -$signed(mag_r) : $signed(mag_r);
    rem1 = (rem0 >= Q_PI) ? rem0 - Q_TWO_PI : rem0;
    rem2 = (rem1 < -Q_PI) ? rem1 + Q_TWO_PI : rem1;
    fold_neg = 1'b0;
    rem3 = rem2;
    if (rem2 > Q_HALF_PI) begin
      rem3 = rem2 - Q_PI;
      fold_neg = 1'b1;
    end else if (rem2 < -Q_HALF_PI) begin
      rem3 = rem2 + Q_PI;
      fold_neg = 1'b1;
    end
  end

  // one CORDIC rotation
  logic signed [33:0] rot_dx, rot_dy, rot_atan;
  assign rot_dx   = cy_r >>> cnt_r;
  assign rot_dy   = cx_r >>> cnt_r;
  assign rot_atan = $signed({2'b00, atan_q30(5'(cnt_r))});

  // CORDIC output rounding
  logic signed [33:0] cos_rnd, sin_rnd;
  assign cos_rnd = (cx_r + 34'sd32) >>> 6;
  assign sin_rnd = (cy_r + 34'sd32) >>> 6;

  // sequencer decisions for the S_FIN state
  logic signed [31:0] y_sum, ed_sum, tgt_sum;
  logic               hit_short, hit_long;
  logic [7:0]         cnt_inc;
  assign y_sum     = sat32(PROD_W'(y_est_r) + PROD_W'(prod_q24));
  assign ed_sum    = sat32(PROD_W'(edge_dist_r) + PROD_W'(s_r));
  assign tgt_sum   = sat32(PROD_W'(theta_new_r) + PROD_W'({1'b0, turn_ang_r}));
  assign hit_short = short_next_r && (ed_sum >= $signed({1'b0, short_len_r}));
  assign hit_long  = ed_sum >= $signed({1'b0, long_len_r});
  assign cnt_inc   = (edge_cnt_r != 8'hff) ? edge_cnt_r + 8'd1 : edge_cnt_r;

  logic [31:0] in_right, in_left;
  assign in_right = in_tdata[31:0];
  assign in_left  = in_tdata[63:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mpt_r        <= 32'd899078;
      iwb_r        <= 31'd209715200;
      short_len_r  <= 31'd10227391;
      long_len_r   <= 31'd15341086;
      turn_ang_r   <= 31'd26340229;
      edge_limit_r <= 8'd12;
      first_r      <= 1'b1;
      prev_r_r     <= '0;
      prev_l_r     <= '0;
      x_est_r      <= '0;
      y_est_r      <= '0;
      theta_est_r  <= '0;
      edge_dist_r  <= '0;
      turn_tgt_r   <= '0;
      turning_r    <= 1'b0;
      short_next_r <= 1'b0;
      edge_cnt_r   <= '0;
      cmd_r        <= CMD_STOP;
      out_tvalid_r <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid) begin
        case (cfg_index)
          REG_METERS_PER_TICK:   mpt_r        <= cfg_data;
          REG_INV_WHEEL_BASE:    iwb_r        <= cfg_data[30:0];
          REG_SHORT_EDGE_LENGTH: short_len_r  <= cfg_data[30:0];
          REG_LONG_EDGE_LENGTH:  long_len_r   <= cfg_data[30:0];
          REG_TURN_ANGLE:        turn_ang_r   <= cfg_data[30:0];
          REG_EDGE_LIMIT:        edge_limit_r <= cfg_data[7:0];
          default: ;
        endcase
      end

      // output valid: set on load in the last state, cleared once the beat is taken
      if ((state_r == S_OUT) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            // first sample: counts become the previous counts, steps zero
            dr_r     <= first_r ? 32'sd0 : $signed(in_right - prev_r_r);
            dl_r     <= first_r ? 32'sd0 : $signed(in_left - prev_l_r);
            prev_r_r <= $signed(in_right);
            prev_l_r <= $signed(in_left);
            first_r  <= 1'b0;
            state_r  <= S_MR;
          end
        end
        S_MR: state_r <= S_ML;
        S_ML: begin
          rs_r    <= step_q;
          state_r <= S_WL;
        end
        S_WL: begin
          ls_r    <= step_q;
          state_r <= S_SD;
        end
        S_SD: begin
          s_r     <= 32'((33'(rs_r) + 33'(ls_r)) >>> 1);
          d_r     <= sat32(PROD_W'(rs_r) - PROD_W'(ls_r));
          state_r <= S_MD;
        end
        S_MD: state_r <= S_DTH;
        S_DTH: begin
          dth_r   <= prod_q24;
          state_r <= S_ANG;
        end
        S_ANG: begin
          theta_new_r <= sat32(PROD_W'(theta_est_r) + PROD_W'(dth_r));
          ang_neg_r   <= ang[33];
          mag_r       <= ang[33] ? 34'(-ang) : 34'(ang);
          mod_k_r     <= 3'd5;
          state_r     <= S_MOD;
        end
        S_MOD: begin
          // restoring subtract of 2pi * 2^k, k from 5 down to 0
          if (mag_r >= mod_sub) begin
            mag_r <= mag_r - mod_sub;
          end
          mod_k_r <= mod_k_r - 3'd1;
          if (mod_k_r == 3'd0) begin
            state_r <= S_FOLD;
          end
        end
        S_FOLD: begin
          cx_r    <= CORDIC_GAIN;
          cy_r    <= '0;
          cz_r    <= rem3 <<< 6;
          fneg_r  <= fold_neg;
          cnt_r   <= '0;
          state_r <= S_ROT;
        end
        S_ROT: begin
          if (!cz_r[33]) begin
            cx_r <= cx_r - rot_dx;
            cy_r <= cy_r + rot_dy;
            cz_r <= cz_r - rot_atan;
          end else begin
            cx_r <= cx_r + rot_dx;
            cy_r <= cy_r - rot_dy;
            cz_r <= cz_r + rot_atan;
          end
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(CORDIC_STEPS - 1)) begin
            state_r <= S_RND;
          end
        end
        S_RND: begin
          c_r     <= fneg_r ? MUL_W'(-cos_rnd) : MUL_W'(cos_rnd);
          sn_r    <= fneg_r ? MUL_W'(-sin_rnd) : MUL_W'(sin_rnd);
          state_r <= S_MX;
        end
        S_MX: state_r <= S_MY;
        S_MY: begin
          x_est_r <= sat32(PROD_W'(x_est_r) + PROD_W'(prod_q24));
          state_r <= S_FIN;
        end
        S_FIN: begin
          y_est_r     <= y_sum;
          theta_est_r <= theta_new_r;
          if (turning_r) begin
            if (theta_new_r >= turn_tgt_r) begin
              turning_r <= 1'b0;
              cmd_r     <= (edge_cnt_r >= edge_limit_r) ? CMD_STOP : CMD_FORWARD;
            end else begin
              cmd_r     <= (edge_cnt_r >= edge_limit_r) ? CMD_STOP : CMD_TURN;
            end
          end else if (hit_short || hit_long) begin
            // edge end: start the corner turn
            short_next_r <= !hit_short;
            edge_dist_r  <= '0;
            turning_r    <= 1'b1;
            edge_cnt_r   <= cnt_inc;
            turn_tgt_r   <= tgt_sum;
            cmd_r        <= (cnt_inc >= edge_limit_r) ? CMD_STOP : CMD_TURN;
          end else begin
            edge_dist_r <= ed_sum;
            cmd_r       <= (edge_cnt_r >= edge_limit_r) ? CMD_STOP : CMD_FORWARD;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {6'd0, edge_cnt_r, edge_dist_r, theta_est_r,
                             y_est_r, x_est_r, cmd_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_ready  = 1'b1;

`ifndef SYNTH
  // an accepted sample keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again right after accept");

  // CORDIC counter stays inside the rotation count
  a_cordic_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) |-> (cnt_r <= CW'(CORDIC_STEPS - 1)))
    else $error("CORDIC counter out of range");

  // completed edge count never goes down
  a_edges_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (edge_cnt_r >= $past(edge_cnt_r)))
    else $error("edge counter decreased");
`endif

endmodule

`default_nettype wire

// ===== design/orps_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on orps_pkg for the operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module orps_mul (
  input  wire                                  clk,
  input  wire logic signed [orps_pkg::MUL_W-1:0]  a_i,
  input  wire logic signed [orps_pkg::MUL_W-1:0]  b_i,
  output logic signed [orps_pkg::PROD_W-1:0]      prod_o
);
  import orps_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  // one multiply per cycle, product ready in the next cycle
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_r;

endmodule

`default_nettype wire

// ===== verif/tb_odometry_rectangle_path_sequencer_unit.sv =====
// Testbench for odometry_rectangle_path_sequencer_unit: drives encoder samples and register
// writes, predicts pose and drive command per sample, checks every result beat.
// Depends on orps_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_odometry_rectangle_path_sequencer_unit;
  import orps_pkg::*;

  localparam int STEPS = 24;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  // pose and sequencer prediction, with a store of expected result beats
  class odo_scoreboard;
    typedef struct {
      move_cmd_t cmd;
      logic [31:0] x, y, th, edge_dist;
      logic [7:0] edges;
    } pose_beat_t;

    longint mpt, iwb, short_len, long_len, turn_ang, limit;
    bit first_pending, turning, short_next;
    longint prev_r, prev_l, x_est, y_est, th_est, dist_acc, target;
    int edges;
    pose_beat_t pose_q[$];
    int errors, results, turns_seen, stops_seen;

    function new();
      mpt = 899078; iwb = 209715200; short_len = 10227391;
      long_len = 15341086; turn_ang = 26340229; limit = 12;
      first_pending = 1; turning = 0; short_next = 0;
      prev_r = 0; prev_l = 0; x_est = 0; y_est = 0; th_est = 0;
      dist_acc = 0; target = 0; edges = 0;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_METERS_PER_TICK:   mpt = val;
        REG_INV_WHEEL_BASE:    iwb = val[30:0];
        REG_SHORT_EDGE_LENGTH: short_len = val[30:0];
        REG_LONG_EDGE_LENGTH:  long_len = val[30:0];
        REG_TURN_ANGLE:        turn_ang = val[30:0];
        REG_EDGE_LIMIT:        limit = val[7:0];
        default: ;
      endcase
    endfunction

    function longint wheel_step(logic [31:0] cur, logic [31:0] prev);
      logic signed [31:0] d;
      longint p;
      d = cur - prev;
      p = longint'(d) * mpt;
      return clip32((p + 128) >>> 8);
    endfunction

    // reduce to [-pi/2, pi/2], then fixed-length CORDIC in Q2.30
    function void sin_cos(longint ang, output longint c, output longint s);
      longint r, x, y, z, dx, dy;
      bit flip;
      r = ang % longint'(Q_TWO_PI);
      flip = 0;
      if (r >= Q_PI) r -= Q_TWO_PI;
      if (r < -Q_PI) r += Q_TWO_PI;
      if (r > Q_HALF_PI) begin
        r -= Q_PI; flip = 1;
      end else if (r < -Q_HALF_PI) begin
        r += Q_PI; flip = 1;
      end
      x = CORDIC_GAIN; y = 0; z = r * 64;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i; dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
        end else begin
          x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
        end
      end
      x = (x + 32) >>> 6;
      y = (y + 32) >>> 6;
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void note_sample(logic [31:0] rc, logic [31:0] lc);
      longint rs, ls, s, d, dth, th, c, sn;
      move_cmd_t cmd;
      pose_beat_t b;
      if (first_pending) begin
        prev_r = longint'(signed'(rc)); prev_l = longint'(signed'(lc));
        first_pending = 0;
      end
      rs = wheel_step(rc, prev_r[31:0]);
      ls = wheel_step(lc, prev_l[31:0]);
      prev_r = longint'(signed'(rc)); prev_l = longint'(signed'(lc));
      s = (rs + ls) >>> 1;
      d = clip32(rs - ls);
      dth = clip32((d * iwb + (64'sd1 << 23)) >>> 24);
      sin_cos(th_est + (dth >>> 1), c, sn);
      th = clip32(th_est + dth);
      if (turning) begin
        if (th >= target) begin
          turning = 0; cmd = CMD_FORWARD;
        end else cmd = CMD_TURN;
      end else begin
        dist_acc = clip32(dist_acc + s);
        if ((short_next && dist_acc >= short_len) || dist_acc >= long_len) begin
          short_next = !(short_next && dist_acc >= short_len);
          dist_acc = 0;
          turning = 1;
          if (edges < 255) edges++;
          target = clip32(th + turn_ang);
          cmd = CMD_TURN;
        end else cmd = CMD_FORWARD;
      end
      x_est = clip32(x_est + ((c * s + (64'sd1 << 23)) >>> 24));
      y_est = clip32(y_est + ((sn * s + (64'sd1 << 23)) >>> 24));
      th_est = th;
      if (edges >= limit) cmd = CMD_STOP;
      if (cmd == CMD_TURN) turns_seen++;
      if (cmd == CMD_STOP) stops_seen++;
      b.cmd = cmd; b.x = x_est[31:0]; b.y = y_est[31:0]; b.th = th_est[31:0];
      b.edge_dist = dist_acc[31:0]; b.edges = edges[7:0];
      pose_q.push_back(b);
    endfunction

    function void check_result(logic [143:0] data);
      pose_beat_t e;
      results++;
      if (pose_q.size() == 0) begin
        $error("result beat with no sample outstanding");
        errors++;
        return;
      end
      e = pose_q.pop_front();
      if (data[1:0] != e.cmd) begin
        $error("move_cmd exp %0d got %0d", e.cmd, data[1:0]); errors++;
      end
      if (data[33:2] != e.x) begin
        $error("pos_x exp %0d got %0d", $signed(e.x), $signed(data[33:2])); errors++;
      end
      if (data[65:34] != e.y) begin
        $error("pos_y exp %0d got %0d", $signed(e.y), $signed(data[65:34])); errors++;
      end
      if (data[97:66] != e.th) begin
        $error("heading exp %0d got %0d", $signed(e.th), $signed(data[97:66])); errors++;
      end
      if (data[129:98] != e.edge_dist) begin
        $error("edge_distance exp %0d got %0d", $signed(e.edge_dist),
               $signed(data[129:98]));
        errors++;
      end
      if (data[137:130] != e.edges) begin
        $error("edges_done exp %0d got %0d", e.edges, data[137:130]); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic [63:0] in_tdata;
  logic in_tvalid, in_tready;
  logic [143:0] out_tdata;
  logic out_tvalid, out_tready;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  odometry_rectangle_path_sequencer_unit #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  odo_scoreboard sb = new();
  bit idling_on = 1;
  bit hold_req = 0;
  logic [31:0] right_cnt = 0, left_cnt = 0;
  int cycles = 0, samples_sent = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: check every accepted beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver back-pressure, plus one long hold-off on request
  initial begin
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_tready <= 1;
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
  endtask

  task automatic send_counts(logic [31:0] rc, logic [31:0] lc);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {lc, rc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(rc, lc);
    samples_sent++;
    right_cnt = rc; left_cnt = lc;
  endtask

  task automatic drain;
    in_tvalid <= 0;
    while (sb.pose_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // mostly driving and turning runs; a few full-range count jumps
  task automatic drive_run(int n);
    int mode, seg, dr, dl;
    seg = 0; mode = 0;
    for (int i = 0; i < n; i++) begin
      if (seg == 0) begin
        mode = $urandom_range(0, 9);
        seg = $urandom_range(3, 30);
      end
      seg--;
      if (mode == 0) begin
        send_counts($urandom, $urandom);
      end else begin
        if (mode <= 6) begin
          dr = $urandom_range(0, 900); dl = dr + $urandom_range(0, 40) - 20;
        end else if (mode <= 8) begin
          dr = $urandom_range(100, 600); dl = -$urandom_range(0, 300);
        end else begin
          dr = -$urandom_range(0, 700); dl = -$urandom_range(0, 700);
        end
        send_counts(right_cnt + dr, left_cnt + dl);
      end
    end
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = 0;
    cfg_valid = 0; cfg_index = REG_METERS_PER_TICK; cfg_data = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: first sample at the extremes, wrap, pure turns, reversing
    send_counts(32'h8000_0000, 32'h7fff_ffff);
    send_counts(32'h7fff_ffff, 32'h8000_0000);
    send_counts(32'h0000_0000, 32'hffff_ffff);
    send_counts(32'hffff_ffff, 32'h0000_0000);
    send_counts(32'h0000_0000, 32'h0000_0000);
    send_counts(32'h0000_0000, 32'h0000_0000);
    for (int i = 0; i < 8; i++) send_counts(right_cnt + 3000, left_cnt + 3000);
    for (int i = 0; i < 4; i++) send_counts(right_cnt + 2000, left_cnt);
    send_counts(right_cnt, left_cnt + 2000);
    send_counts(right_cnt - 5000, left_cnt - 5000);
    send_counts(right_cnt + 32'h4000_0000, left_cnt - 32'h4000_0000);

    // default geometry, with a long receiver hold-off part way
    drive_run(150);
    hold_req = 1;
    drive_run(150);
    drain();

    // extremes: largest scales, zero lengths and angle, stop from the start
    write_reg(REG_METERS_PER_TICK, 32'hffff_ffff);
    write_reg(REG_INV_WHEEL_BASE, 32'hffff_ffff);
    write_reg(REG_SHORT_EDGE_LENGTH, 32'h0);
    write_reg(REG_LONG_EDGE_LENGTH, 32'h0);
    write_reg(REG_TURN_ANGLE, 32'h0);
    write_reg(REG_EDGE_LIMIT, 32'h0);
    write_reg(REG_SPARE_A, 32'hdead_beef);
    drive_run(100);
    drain();

    // short edges, huge turn angle, counter up to saturation
    write_reg(REG_METERS_PER_TICK, 32'd4_000_000);
    write_reg(REG_INV_WHEEL_BASE, 32'd100_000_000);
    write_reg(REG_SHORT_EDGE_LENGTH, 32'd100_000);
    write_reg(REG_LONG_EDGE_LENGTH, 32'd300_000);
    write_reg(REG_TURN_ANGLE, 32'h7fff_ffff);
    write_reg(REG_EDGE_LIMIT, 32'hffff_ff00 | 8'd255);
    write_reg(REG_SPARE_B, 32'h1234_5678);
    drive_run(150);
    drain();

    // random geometry
    write_reg(REG_METERS_PER_TICK, $urandom);
    write_reg(REG_INV_WHEEL_BASE, $urandom);
    write_reg(REG_SHORT_EDGE_LENGTH, $urandom_range(0, 20_000_000));
    write_reg(REG_LONG_EDGE_LENGTH, $urandom_range(0, 40_000_000));
    write_reg(REG_TURN_ANGLE, $urandom_range(0, 60_000_000));
    write_reg(REG_EDGE_LIMIT, $urandom);
    drive_run(150);
    drain();

    // back to the default scales and turn angle, shorter edges, full rate on both sides
    write_reg(REG_METERS_PER_TICK, 32'd899078);
    write_reg(REG_INV_WHEEL_BASE, 32'd209715200);
    write_reg(REG_SHORT_EDGE_LENGTH, 32'd1_000_000);
    write_reg(REG_LONG_EDGE_LENGTH, 32'd2_000_000);
    write_reg(REG_TURN_ANGLE, 32'd26340229);
    write_reg(REG_EDGE_LIMIT, 32'd200);
    idling_on = 0;
    drive_run(150);
    drain();

    $display("Run covered %0d samples, %0d result beats, %0d turn and %0d stop commands,",
             samples_sent, sb.results, sb.turns_seen, sb.stops_seen);
    $display("over five register settings with the extremes and a long output stall.");
    if (sb.errors == 0 && sb.pose_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/orps_pkg.sv
design/orps_mul.sv
design/odometry_rectangle_path_sequencer_unit.sv
verif/tb_odometry_rectangle_path_sequencer_unit.sv
